// ----- hdl/checked_stack_calculator_assert.svh -----
// assertion macros for the stack calculator checker
`ifndef CHECKED_STACK_CALCULATOR_ASSERT_SVH
`define CHECKED_STACK_CALCULATOR_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg
// shared types, codes and sizes of the checked stack calculator
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int VAR_SLOTS_DEF   = 16;

    localparam logic [3:0] CMD_PUSH  = 4'd0;
    localparam logic [3:0] CMD_PUSHV = 4'd1;
    localparam logic [3:0] CMD_POP   = 4'd2;
    localparam logic [3:0] CMD_PEEK  = 4'd3;
    localparam logic [3:0] CMD_ABS   = 4'd4;
    localparam logic [3:0] CMD_ADD   = 4'd5;
    localparam logic [3:0] CMD_SUB   = 4'd6;
    localparam logic [3:0] CMD_MUL   = 4'd7;
    localparam logic [3:0] CMD_DIV   = 4'd8;
    localparam logic [3:0] CMD_PRINT = 4'd9;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FEW   = 3'd1;
    localparam logic [2:0] ST_UNSET = 3'd2;
    localparam logic [2:0] ST_OVF   = 3'd3;
    localparam logic [2:0] ST_DIV0  = 3'd4;
    localparam logic [2:0] ST_FULL  = 3'd5;

    // request to the shared multiply/divide unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] a;
        logic [63:0] b;
    } csc_alu_req_t;

    // answer of the shared multiply/divide unit
    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [63:0] result;
    } csc_alu_rsp_t;

endpackage

// ----- hdl/csc_muldiv.sv -----
// ----------------------------------------------------------------------------
// csc_muldiv
// bit-serial checked multiply and restoring divide on 64-bit magnitudes
// ----------------------------------------------------------------------------
module csc_muldiv (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csc_pkg::csc_alu_req_t req,
    output csc_pkg::csc_alu_rsp_t rsp
);
    import csc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         div_reg, div_next;
    logic         neg_reg, neg_next;
    logic         ovf_reg, ovf_next;
    logic [63:0]  mb_reg, mb_next;   // multiplier / divisor magnitude
    logic [63:0]  ma_reg, ma_next;   // multiplicand / dividend-quotient
    logic [64:0]  acc_reg, acc_next; // product sum / remainder
    logic         done_reg, done_next;
    logic [63:0]  res_reg, res_next;

    logic [63:0]  mag_a, mag_b;
    logic [64:0]  sum;
    logic [64:0]  rem_sh;
    logic [65:0]  diff;
    logic [64:0]  lim;
    logic [63:0]  mag_res;

    assign mag_a = req.a[63] ? (64'd0 - req.a) : req.a;
    assign mag_b = req.b[63] ? (64'd0 - req.b) : req.b;
    // multiply scans the multiplier from msb: acc = 2*acc + bit*ma
    assign sum    = {acc_reg[63:0], 1'b0} + (mb_reg[63] ? {1'b0, ma_reg} : 65'd0);
    assign rem_sh = {acc_reg[63:0], ma_reg[63]};
    assign diff   = {1'b0, rem_sh} - {2'b00, mb_reg};
    assign lim    = neg_reg ? {1'b0, 64'h8000_0000_0000_0000}
                            : {1'b0, 64'h7fff_ffff_ffff_ffff};
    assign mag_res = div_reg ? ma_reg : acc_reg[63:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        mb_next    = mb_reg;
        ma_next    = ma_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    div_next   = req.is_div;
                    neg_next   = req.a[63] ^ req.b[63];
                    ovf_next   = 1'b0;
                    ma_next    = mag_a;
                    mb_next    = mag_b;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (div_reg)
                begin
                    if (!diff[65])
                    begin
                        acc_next = diff[64:0];
                        ma_next  = {ma_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_sh;
                        ma_next  = {ma_reg[62:0], 1'b0};
                    end
                end
                else
                begin
                    // any partial sum past the limit stays past it
                    if (sum > lim || acc_reg[64])
                        ovf_next = 1'b1;
                    acc_next = sum;
                    mb_next  = {mb_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!div_reg && acc_reg > lim)
                    ovf_next = 1'b1;
                res_next   = neg_reg ? (64'd0 - mag_res) : mag_res;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        mb_reg  <= mb_next;
        ma_reg  <= ma_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.ovf    = ovf_reg;
    assign rsp.result = res_reg;

endmodule

// ----- hdl/checked_stack_calculator.sv -----
// ----------------------------------------------------------------------------
// checked_stack_calculator
// checked 64-bit signed stack machine with variable slots
// ----------------------------------------------------------------------------
// channel  dir  tdata                               tuser
// s_axis   in   cmd[3:0] value[67:4] var_slot[71:68]  -
// m_axis   out  status[2:0] printed[3] pval[67:4]    -
//
// push, pop, peek, abs, add, sub and print pass through stack memory
// read, then compute, then result. mul and div wait after compute on the
// shared multiply/divide unit, which works one bit per cycle.
// reset clears the entry count and the variable set mask; memories hold.
// s_axis_tready stays low from acceptance until the result is taken.
module checked_stack_calculator #(
    parameter int STACK_DEPTH = csc_pkg::STACK_DEPTH_DEF,
    parameter int VAR_SLOTS   = csc_pkg::VAR_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // cmd, value, var_slot
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // status, printed, print_value, zero fill
);
    import csc_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int VAW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXE  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [63:0] stk_mem [STACK_DEPTH];
    logic [63:0] var_mem [VAR_SLOTS];

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [VAR_SLOTS-1:0] mask_reg, mask_next;
    logic [3:0]          cmd_reg;
    logic [63:0]         val_reg;
    logic [3:0]          slot_reg;
    logic [63:0]         top_reg, sec_reg, vr_reg;
    logic [2:0]          st_reg, st_next;
    logic                pr_reg, pr_next;
    logic [63:0]         pv_reg, pv_next;

    logic                stk_we;
    logic [SAW-1:0]      stk_wa;
    logic [63:0]         stk_wd;
    logic                var_we;
    logic                alu_start;

    csc_alu_req_t alu_req;
    csc_alu_rsp_t alu_rsp;

    logic [CW-1:0]  cm1, cm2;
    logic [63:0]    add_r, sub_r;
    logic           slot_ok, slot_set;
    logic [VAW-1:0] slot_idx;

    assign cm1 = cnt_reg - CW'(1);
    assign cm2 = cnt_reg - CW'(2);
    assign add_r = sec_reg + top_reg;
    assign sub_r = sec_reg - top_reg;
    assign slot_idx = VAW'(slot_reg);
    assign slot_ok  = ({28'd0, slot_reg} < VAR_SLOTS);
    assign slot_set = slot_ok && mask_reg[slot_idx];

    csc_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign alu_req.start  = alu_start;
    assign alu_req.is_div = (cmd_reg == CMD_DIV);
    assign alu_req.a      = sec_reg;
    assign alu_req.b      = top_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mask_next     = mask_reg;
        st_next       = st_reg;
        pr_next       = pr_reg;
        pv_next       = pv_reg;
        stk_we        = 1'b0;
        stk_wa        = cnt_reg[SAW-1:0];
        stk_wd        = val_reg;
        var_we        = 1'b0;
        alu_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_RD;
            end
            S_RD: state_next = S_EXE;
            S_EXE:
            begin
                st_next    = ST_OK;
                pr_next    = 1'b0;
                pv_next    = '0;
                state_next = S_OUT;
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (cnt_reg == CW'(STACK_DEPTH))
                            st_next = ST_FULL;
                        else
                        begin
                            stk_we   = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    CMD_PUSHV:
                    begin
                        if (!slot_set)
                            st_next = ST_UNSET;
                        else if (cnt_reg == CW'(STACK_DEPTH))
                            st_next = ST_FULL;
                        else
                        begin
                            stk_we   = 1'b1;
                            stk_wd   = vr_reg;
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (cnt_reg == '0)
                            st_next = ST_FEW;
                        else
                            cnt_next = cm1;
                    end
                    CMD_PEEK:
                    begin
                        if (cnt_reg == '0)
                            st_next = ST_FEW;
                        else if (slot_ok)
                        begin
                            var_we = 1'b1;
                            mask_next[slot_idx] = 1'b1;
                        end
                    end
                    CMD_ABS:
                    begin
                        if (cnt_reg == '0)
                            st_next = ST_FEW;
                        else if (top_reg == 64'h8000_0000_0000_0000)
                            st_next = ST_OVF;
                        else
                        begin
                            stk_we = 1'b1;
                            stk_wa = cm1[SAW-1:0];
                            stk_wd = top_reg[63] ? (64'd0 - top_reg) : top_reg;
                        end
                    end
                    CMD_ADD, CMD_SUB:
                    begin
                        if (cnt_reg < CW'(2))
                            st_next = ST_FEW;
                        else if (cmd_reg == CMD_ADD &&
                                 sec_reg[63] == top_reg[63] && add_r[63] != sec_reg[63])
                            st_next = ST_OVF;
                        else if (cmd_reg == CMD_SUB &&
                                 sec_reg[63] != top_reg[63] && sub_r[63] != sec_reg[63])
                            st_next = ST_OVF;
                        else
                        begin
                            stk_we   = 1'b1;
                            stk_wa   = cm2[SAW-1:0];
                            stk_wd   = (cmd_reg == CMD_ADD) ? add_r : sub_r;
                            cnt_next = cm1;
                        end
                    end
                    CMD_MUL, CMD_DIV:
                    begin
                        if (cnt_reg < CW'(2))
                            st_next = ST_FEW;
                        else if (cmd_reg == CMD_DIV && top_reg == '0)
                            st_next = ST_DIV0;
                        else if (cmd_reg == CMD_DIV && sec_reg == 64'h8000_0000_0000_0000
                                 && top_reg == '1)
                            st_next = ST_OVF;
                        else
                        begin
                            alu_start  = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    CMD_PRINT:
                    begin
                        if (cnt_reg == '0)
                            st_next = ST_FEW;
                        else
                        begin
                            pr_next = 1'b1;
                            pv_next = top_reg;
                        end
                    end
                    default: st_next = ST_OK;
                endcase
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_OUT;
                    if (alu_rsp.ovf && cmd_reg == CMD_MUL)
                        st_next = ST_OVF;
                    else
                    begin
                        stk_we   = 1'b1;
                        stk_wa   = cm2[SAW-1:0];
                        stk_wd   = alu_rsp.result;
                        cnt_next = cm1;
                    end
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            cmd_reg  <= s_axis_tdata[3:0];
            val_reg  <= s_axis_tdata[67:4];
            slot_reg <= s_axis_tdata[71:68];
        end
        if (state_reg == S_RD)
        begin
            top_reg <= stk_mem[cm1[SAW-1:0]];
            sec_reg <= stk_mem[cm2[SAW-1:0]];
            vr_reg  <= var_mem[slot_idx];
        end
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        if (var_we)
            var_mem[slot_idx] <= top_reg;
        st_reg <= st_next;
        pr_reg <= pr_next;
        pv_reg <= pv_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {4'd0, pv_reg, pr_reg, st_reg};

endmodule

// ----- hdl/csc_checker.sv -----
// ----------------------------------------------------------------------------
// csc_checker
// port-level checks of the stack calculator handshakes and results
// ----------------------------------------------------------------------------
`include "checked_stack_calculator_assert.svh"

module csc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    import csc_pkg::*;

    // one transaction in flight: no input taken while a result is shown
    `CSC_ASSERT_IMPL(a_excl, m_axis_tvalid, !s_axis_tready, "input ready during result")
    // a stalled result holds its data
    `CSC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
    // printed only with status ok
    `CSC_ASSERT_IMPL(a_pr, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[2:0] == ST_OK, "print with error status")
    // status code in range
    `CSC_ASSERT_IMPL(a_st, m_axis_tvalid, m_axis_tdata[2:0] <= ST_FULL, "bad status code")
    // an accepted input leaves ready low next cycle
    `CSC_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after transaction")
endmodule

bind checked_stack_calculator csc_checker u_csc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
